[rtl/integer_to_ascii_formatter_assert.svh]
// assertion macros for the integer to ascii formatter
// used by the top level only, no other dependencies
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// consequent checked in the same cycle
`define I2A_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define I2A_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2a_pkg.sv]
// shared types, constants and microcode table of the integer to ascii formatter
// no dependencies
package i2a_pkg;

    localparam int ValueW    = 32;
    localparam int CmdW      = 2;
    localparam int CharW     = 8;
    localparam int DigitW    = 4;
    localparam int NumDigits = 10;
    localparam int BcdW      = NumDigits * DigitW;
    localparam int CntW      = 4;
    localparam int BitCntW   = 5;
    localparam int PcW       = 3;

    localparam logic [CmdW-1:0] CMD_UDEC = 2'd0;
    localparam logic [CmdW-1:0] CMD_SDEC = 2'd1;
    localparam logic [CmdW-1:0] CMD_HEX  = 2'd2;

    localparam logic [CharW-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CharW-1:0]  CHAR_A     = 8'h41;
    localparam logic [CharW-1:0]  CHAR_MINUS = 8'h2d;
    localparam logic [DigitW-1:0] DEC_BASE   = 4'd10;

    localparam logic [CntW-1:0]    DIGITS_INIT = CntW'(NumDigits);
    localparam logic [BitCntW-1:0] LAST_BIT    = BitCntW'(ValueW - 1);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SIGN,
        OP_DABBLE,
        OP_SKIP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_NEG,
        COND_HEX,
        COND_BITS_LEFT,
        COND_LEAD_ZERO,
        COND_MORE_DIGITS
    } cond_t;

    typedef struct packed {
        op_t            op;
        cond_t          cond;
        logic [PcW-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic go;
    } ctrl_t;

    typedef struct packed {
        logic neg;
        logic hex;
        logic bits_left;
        logic lead_zero;
        logic more_digits;
        logic out_free;
    } stat_t;

    // program: load, optional sign, binary to bcd for decimal modes, skip leading zeros, emit
    function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
        uword_t w;
        case (pc)
            3'd0:    w = '{OP_LOAD,   COND_NEVER,       3'd0};
            3'd1:    w = '{OP_NOP,    COND_NOT_NEG,     3'd3};
            3'd2:    w = '{OP_SIGN,   COND_NEVER,       3'd0};
            3'd3:    w = '{OP_NOP,    COND_HEX,         3'd5};
            3'd4:    w = '{OP_DABBLE, COND_BITS_LEFT,   3'd4};
            3'd5:    w = '{OP_SKIP,   COND_LEAD_ZERO,   3'd5};
            3'd6:    w = '{OP_EMIT,   COND_MORE_DIGITS, 3'd6};
            3'd7:    w = '{OP_NOP,    COND_ALWAYS,      3'd0};
            default: w = '{OP_NOP,    COND_ALWAYS,      3'd0};
        endcase
        return w;
    endfunction

    function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
        logic [CharW-1:0] c;
        if (d >= DEC_BASE) begin
            c = CHAR_A + CharW'(d - DEC_BASE);
        end else begin
            c = CHAR_ZERO + CharW'(d);
        end
        return c;
    endfunction

endpackage

[rtl/i2a_sequencer.sv]
// microcode sequencer: step counter, table lookup, stall and conditional jump
// depends on i2a_pkg
module i2a_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  i2a_pkg::stat_t stat,
    output i2a_pkg::ctrl_t ctrl
);

    logic [i2a_pkg::PcW-1:0] pc_reg;
    logic [i2a_pkg::PcW-1:0] pc_next;
    i2a_pkg::uword_t         uw;
    logic                    stall;
    logic                    take;

    always_comb begin
        uw = i2a_pkg::ucode_rom(pc_reg);

        case (uw.op)
            i2a_pkg::OP_LOAD: stall = !s_tvalid;
            i2a_pkg::OP_SIGN: stall = !stat.out_free;
            i2a_pkg::OP_EMIT: stall = !stat.out_free;
            default:          stall = 1'b0;
        endcase

        case (uw.cond)
            i2a_pkg::COND_ALWAYS:      take = 1'b1;
            i2a_pkg::COND_NOT_NEG:     take = !stat.neg;
            i2a_pkg::COND_HEX:         take = stat.hex;
            i2a_pkg::COND_BITS_LEFT:   take = stat.bits_left;
            i2a_pkg::COND_LEAD_ZERO:   take = stat.lead_zero;
            i2a_pkg::COND_MORE_DIGITS: take = stat.more_digits;
            default:                   take = 1'b0;
        endcase

        if (stall) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end

        ctrl.op = uw.op;
        ctrl.go = !stall;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/i2a_datapath.sv]
// datapath: magnitude and bcd shift registers, digit counter, output register
// depends on i2a_pkg
module i2a_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  i2a_pkg::ctrl_t                 ctrl,
    input  logic [i2a_pkg::ValueW-1:0]     s_tdata,
    input  logic [i2a_pkg::CmdW-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2a_pkg::CharW-1:0]      m_tdata,
    output logic                           m_tlast,
    output i2a_pkg::stat_t                 stat
);

    logic [i2a_pkg::ValueW-1:0]  mag_reg,    mag_next;
    logic [i2a_pkg::BcdW-1:0]    digits_reg, digits_next;
    logic [i2a_pkg::CntW-1:0]    cnt_reg,    cnt_next;
    logic [i2a_pkg::BitCntW-1:0] bit_reg,    bit_next;
    logic                        neg_reg,    neg_next;
    logic                        hex_reg,    hex_next;
    logic                        ovalid_reg, ovalid_next;
    logic [i2a_pkg::CharW-1:0]   ochar_reg,  ochar_next;
    logic                        olast_reg,  olast_next;

    logic [i2a_pkg::BcdW-1:0]    adj;
    logic [i2a_pkg::DigitW-1:0]  top_digit;
    logic                        out_free;
    logic                        in_neg;

    assign top_digit = digits_reg[i2a_pkg::BcdW-1 -: i2a_pkg::DigitW];
    assign out_free  = !ovalid_reg || m_tready;
    assign in_neg    = (s_tuser == i2a_pkg::CMD_SDEC) && s_tdata[i2a_pkg::ValueW-1];

    always_comb begin
        stat.neg         = neg_reg;
        stat.hex         = hex_reg;
        stat.bits_left   = bit_reg != i2a_pkg::LAST_BIT;
        stat.lead_zero   = (top_digit == '0) && (cnt_reg > 1);
        stat.more_digits = cnt_reg > 1;
        stat.out_free    = out_free;
    end

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        logic [i2a_pkg::DigitW-1:0] dg;
        dg = '0;
        for (int i = 0; i < i2a_pkg::NumDigits; i++) begin
            dg = digits_reg[i*i2a_pkg::DigitW +: i2a_pkg::DigitW];
            adj[i*i2a_pkg::DigitW +: i2a_pkg::DigitW] = (dg >= 4'd5) ? dg + 4'd3 : dg;
        end
    end

    always_comb begin
        mag_next    = mag_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        bit_next    = bit_reg;
        neg_next    = neg_reg;
        hex_next    = hex_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !m_tready;

        if (ctrl.go) begin
            case (ctrl.op)
                i2a_pkg::OP_LOAD: begin
                    neg_next = in_neg;
                    hex_next = s_tuser == i2a_pkg::CMD_HEX;
                    mag_next = in_neg ? (i2a_pkg::ValueW'(0) - s_tdata) : s_tdata;
                    digits_next = (s_tuser == i2a_pkg::CMD_HEX) ?
                                  i2a_pkg::BcdW'(s_tdata) : '0;
                    cnt_next = i2a_pkg::DIGITS_INIT;
                    bit_next = '0;
                end
                i2a_pkg::OP_SIGN: begin
                    ovalid_next = 1'b1;
                    ochar_next  = i2a_pkg::CHAR_MINUS;
                    olast_next  = 1'b0;
                end
                i2a_pkg::OP_DABBLE: begin
                    digits_next = {adj[i2a_pkg::BcdW-2:0], mag_reg[i2a_pkg::ValueW-1]};
                    mag_next    = {mag_reg[i2a_pkg::ValueW-2:0], 1'b0};
                    bit_next    = bit_reg + 1'b1;
                end
                i2a_pkg::OP_SKIP: begin
                    if (stat.lead_zero) begin
                        digits_next = digits_reg << i2a_pkg::DigitW;
                        cnt_next    = cnt_reg - 1'b1;
                    end
                end
                i2a_pkg::OP_EMIT: begin
                    ovalid_next = 1'b1;
                    ochar_next  = i2a_pkg::digit_char(top_digit);
                    olast_next  = cnt_reg == 1;
                    digits_next = digits_reg << i2a_pkg::DigitW;
                    cnt_next    = cnt_reg - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        bit_reg    <= bit_next;
        neg_reg    <= neg_next;
        hex_reg    <= hex_next;
        ochar_reg  <= ochar_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ochar_reg;
    assign m_tlast  = olast_reg;

endmodule

[rtl/integer_to_ascii_formatter.sv]
// Integer to ASCII formatter. Takes one 32-bit value with a mode on tuser
// (0 unsigned decimal, 1 signed decimal, 2 uppercase hex, 3 as unsigned decimal) and
// sends the number as ASCII characters, most significant first, no leading zeros,
// a single '0' for zero and a leading '-' for negative signed values; tlast marks
// the final character. One number is handled at a time by a small microcoded
// sequencer. A decimal number passes the setup steps (load, sign test, the minus
// sign when negative, mode test), 32 one-bit-per-cycle binary to bcd steps, then
// leading zero skipping and character output (one character per cycle while the
// output is not stalled). A hex number skips the binary to bcd steps. The next
// number is accepted while the last character still waits in the output register.
// depends on i2a_pkg, i2a_sequencer, i2a_datapath and the assertion macro header
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2a_pkg::ValueW-1:0]    s_tdata,   // [31:0] value
    input  logic [i2a_pkg::CmdW-1:0]      s_tuser,   // [1:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2a_pkg::CharW-1:0]     m_tdata,   // [7:0] character
    output logic                          m_tlast
);

    i2a_pkg::ctrl_t ctrl;
    i2a_pkg::stat_t stat;

    assign s_tready = ctrl.op == i2a_pkg::OP_LOAD;

    i2a_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    i2a_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    // a new number only starts once the previous one has reached its last character
    `I2A_ASSERT_NOW(a_ready_after_last, aclk, aresetn, s_tready && m_tvalid, m_tlast, "input ready mid-number")
    // one number at a time
    `I2A_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second transfer accepted")
    // the minus sign is never the final character
    `I2A_ASSERT_NOW(a_minus_not_last, aclk, aresetn, m_tvalid && (m_tdata == i2a_pkg::CHAR_MINUS), !m_tlast, "minus flagged last")

endmodule

[tb/format_checker.sv]
// character stream checker for the integer to ascii formatter
// predicts the ascii characters of every accepted number and compares them in order
// depends on i2a_pkg only
module format_checker
    import i2a_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [ValueW-1:0]   s_tdata,    // [31:0] value
    input  logic [CmdW-1:0]     s_tuser,    // [1:0] command
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [CharW-1:0]    m_tdata,    // [7:0] character
    input  logic                m_tlast,
    output int                  mismatch_count,
    output int                  chars_pending,
    output int                  numbers_seen,
    output int                  chars_seen
);

    localparam int DEC_RADIX  = 10;
    localparam int HEX_RADIX  = 16;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [CharW-1:0] character;
        logic             last;
    } char_item_t;

    char_item_t expected_chars[$];

    // digits are built least significant first, then queued in print order
    function automatic void format_number(input logic [CmdW-1:0] cmd,
                                          input logic [ValueW-1:0] value);
        logic [ValueW-1:0] mag;
        logic [ValueW-1:0] radix;
        logic [ValueW-1:0] rem;
        logic [CharW-1:0]  digits[$];
        char_item_t        item;
        mag   = value;
        radix = DEC_RADIX;
        if (cmd == CMD_HEX) begin
            radix = HEX_RADIX;
        end else if (cmd == CMD_SDEC && value[ValueW-1]) begin
            item.character = CHAR_MINUS;
            item.last      = 1'b0;
            expected_chars.push_back(item);
            mag = -value;
        end
        do begin
            rem = mag % radix;
            if (rem >= DEC_RADIX) begin
                digits.push_front(CHAR_A + CharW'(rem - DEC_RADIX));
            end else begin
                digits.push_front(CHAR_ZERO + CharW'(rem));
            end
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[k]) begin
            item.character = digits[k];
            item.last      = (k == digits.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    task automatic log_failure(input string text);
        if (mismatch_count < MAX_REPORT) begin
            $display("[%0t] %s", $realtime, text);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        char_item_t want;
        if (!aresetn) begin
            mismatch_count = 0;
            numbers_seen   = 0;
            chars_seen     = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                format_number(s_tuser, s_tdata);
                numbers_seen++;
            end
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    log_failure($sformatf("unexpected character %02h last %0b",
                                          m_tdata, m_tlast));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.character || m_tlast !== want.last) begin
                        log_failure($sformatf(
                            "char %0d: expected %02h last %0b, got %02h last %0b",
                            chars_seen, want.character, want.last, m_tdata, m_tlast));
                    end
                end
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

[tb/tb.sv]
// top of the integer to ascii formatter testbench: clock, reset, number stimulus,
// output back-pressure and the final verdict
// depends on i2a_pkg, integer_to_ascii_formatter and format_checker
module tb;
    import i2a_pkg::*;

    localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;   // unused code, formats as unsigned
    localparam int RANDOM_NUMBERS = 340;
    localparam int QUIET_TAIL     = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_NUMBERS   = 10;
    localparam int DRAIN_CYCLES   = 80;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [ValueW-1:0] s_tdata;     // [31:0] value
    logic [CmdW-1:0]   s_tuser;     // [1:0] command
    logic              m_tvalid;
    logic              m_tready;
    logic [CharW-1:0]  m_tdata;     // [7:0] character
    logic              m_tlast;

    int mismatch_count;
    int chars_pending;
    int numbers_seen;
    int chars_seen;

    logic src_idle_on;
    logic sink_idle_on;
    logic hold_request;

    integer_to_ascii_formatter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    format_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending),
        .numbers_seen   (numbers_seen),
        .chars_seen     (chars_seen)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d characters still expected", chars_pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sink side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request <= 1'b0;
                m_tready     <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic offer_number(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (chars_pending == 0);
        @(negedge aclk);
    endtask

    function automatic logic [ValueW-1:0] random_value();
        logic [ValueW-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom();
            1:       v = $urandom_range(0, 99);
            2:       v = $urandom() >> $urandom_range(0, 31);
            3:       v = ValueW'(0) - ValueW'($urandom_range(1, 1000));
            4:       v = ValueW'({1'b1, ValueW'(0)} >> $urandom_range(1, 32));
            default: v = $urandom() | {1'b1, {(ValueW-1){1'b0}}};
        endcase
        return v;
    endfunction

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_UDEC;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_request = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes, each mode, zero, most negative, and the spare code
        offer_number(CMD_UDEC, 32'd0);
        offer_number(CMD_UDEC, 32'd9);
        offer_number(CMD_UDEC, 32'd10);
        offer_number(CMD_UDEC, 32'd1000000000);
        offer_number(CMD_UDEC, 32'hFFFFFFFF);
        offer_number(CMD_SDEC, 32'd0);
        offer_number(CMD_SDEC, 32'd123);
        offer_number(CMD_SDEC, 32'h7FFFFFFF);
        offer_number(CMD_SDEC, 32'h80000000);
        offer_number(CMD_SDEC, 32'hFFFFFFFF);
        offer_number(CMD_SDEC, 32'hFFFFFFF6);
        offer_number(CMD_HEX, 32'd0);
        offer_number(CMD_HEX, 32'h0000000F);
        offer_number(CMD_HEX, 32'h00000010);
        offer_number(CMD_HEX, 32'hABCDEF01);
        offer_number(CMD_HEX, 32'h80000000);
        offer_number(CMD_HEX, 32'hFFFFFFFF);
        offer_number(CMD_SPARE, 32'd0);
        offer_number(CMD_SPARE, 32'd42);
        offer_number(CMD_SPARE, 32'hFFFFFFFF);

        // sink holds off while numbers keep coming, then everything drains
        hold_request <= 1'b1;
        repeat (HOLD_NUMBERS) begin
            offer_number(CmdW'($urandom_range(0, 3)), random_value());
        end
        wait_drained();

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n == RANDOM_NUMBERS - QUIET_TAIL) begin
                src_idle_on  <= 1'b0;
                sink_idle_on <= 1'b0;
            end
            offer_number(CmdW'($urandom_range(0, 3)), random_value());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("formatted %0d numbers over all command codes, %0d characters compared",
                 numbers_seen, chars_seen);
        if (mismatch_count == 0 && chars_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
